// ----- sv/sdm_pkg.sv -----
package sdm_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int FRAC_W     = 16;
    localparam int GRID_MAX   = 4096;
    localparam int SIZE_W     = 13;
    localparam int STEP_W     = 31;
    localparam int INDEX_W    = 24;
    localparam int OP_W       = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 31;

    // Global index and the wrap dividends.
    localparam int GLOBAL_W = INDEX_W + 1;
    localparam int WRAP_W   = GLOBAL_W + 1;

    // Wavenumber magnitude: index distance times step.
    localparam int KMAG_W = SIZE_W + STEP_W;

    // Any factor at or above 2^CLAMP_EXP saturates every nonzero sample,
    // so factors are held there without changing a result.
    localparam int CLAMP_EXP = SAMPLE_W + FRAC_W;
    localparam int FAC_W     = CLAMP_EXP + 1;
    localparam int KSQ_W     = (CLAMP_EXP + FRAC_W) / 2;
    localparam int SQ_W      = 2 * KSQ_W;
    localparam int FLO_W     = 32;
    localparam int FHI_W     = FAC_W - FLO_W;
    localparam int PLO_W     = FLO_W + SAMPLE_W;
    localparam int PHI_W     = FHI_W + SAMPLE_W;
    localparam int PROD_W    = PHI_W + FLO_W;
    localparam int P_W       = PROD_W - FRAC_W;

    localparam logic [OP_W-1:0] OP_LAPLACE = 3'd0;
    localparam logic [OP_W-1:0] OP_DDX     = 3'd1;
    localparam logic [OP_W-1:0] OP_DDY     = 3'd2;
    localparam logic [OP_W-1:0] OP_D2X     = 3'd3;
    localparam logic [OP_W-1:0] OP_D2Y     = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] REG_GRID_X    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_Y    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SHIFT_X   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SHIFT_Y   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_KX   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_KY   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SLAB      = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_OPERATION = 3'd7;

    typedef struct packed {
        logic [SIZE_W-1:0] shift_x;
        logic [SIZE_W-1:0] shift_y;
        logic [STEP_W-1:0] step_kx;
        logic [STEP_W-1:0] step_ky;
    } cfg_t;

    typedef struct packed {
        logic [KMAG_W-1:0]   kx_mag;
        logic                kx_neg;
        logic [KMAG_W-1:0]   ky_mag;
        logic                ky_neg;
        logic                sqx_big;
        logic [SQ_W-1:0]     sqx;
        logic                sqy_big;
        logic [SQ_W-1:0]     sqy;
        logic [SAMPLE_W-1:0] re;
        logic [SAMPLE_W-1:0] im;
    } wave_t;

endpackage

// ----- sv/sdm_div.sv -----
module sdm_div #(
    parameter int W      = 25,
    parameter int DW     = 13,
    parameter int LANES  = 1,
    parameter int SIDE_W = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [W-1:0]      dividend [LANES],
    input  logic [DW-1:0]     divisor [LANES],
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [W-1:0]      quotient [LANES],
    output logic [DW-1:0]     remainder [LANES],
    output logic [SIDE_W-1:0] side_out
);

    // One quotient bit per stage, most significant first.
    logic              valid_reg [W];
    logic              adv [W];
    logic [W-1:0]      num_reg [W][LANES];
    logic [DW-1:0]     rem_reg [W][LANES];
    logic [SIDE_W-1:0] side_reg [W];

    genvar s, l;
    generate
        for (s = 0; s < W; s++)
        begin : g_stage
            logic [W-1:0]      num_in [LANES];
            logic [DW-1:0]     rem_in [LANES];
            logic [SIDE_W-1:0] side_i;
            logic              valid_in;

            if (s == 0)
            begin : g_first
                assign valid_in = in_valid;
                assign side_i   = side_in;
                for (l = 0; l < LANES; l++)
                begin : g_in
                    assign num_in[l] = dividend[l];
                    assign rem_in[l] = '0;
                end
            end
            else
            begin : g_next
                assign valid_in = valid_reg[s-1];
                assign side_i   = side_reg[s-1];
                for (l = 0; l < LANES; l++)
                begin : g_in
                    assign num_in[l] = num_reg[s-1][l];
                    assign rem_in[l] = rem_reg[s-1][l];
                end
            end

            // A stage moves when it is empty or the next one moves.
            if (s == W - 1)
            begin : g_last
                assign adv[s] = !valid_reg[s] || out_ready;
            end
            else
            begin : g_mid
                assign adv[s] = !valid_reg[s] || adv[s+1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (adv[s])
                begin
                    valid_reg[s] <= valid_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[s])
                begin
                    side_reg[s] <= side_i;
                end
            end

            for (l = 0; l < LANES; l++)
            begin : g_lane
                logic [DW:0]   trial;
                logic          ge;
                logic [DW-1:0] rem_next;

                assign trial    = {rem_in[l], num_in[l][W-1]};
                assign ge       = trial >= {1'b0, divisor[l]};
                assign rem_next = ge ? DW'(trial - {1'b0, divisor[l]}) : trial[DW-1:0];

                always_ff @(posedge clk)
                begin
                    if (adv[s])
                    begin
                        rem_reg[s][l] <= rem_next;
                        num_reg[s][l] <= {num_in[l][W-2:0], ge};
                    end
                end
            end
        end

        for (l = 0; l < LANES; l++)
        begin : g_out
            assign quotient[l]  = num_reg[W-1][l];
            assign remainder[l] = rem_reg[W-1][l];
        end
    endgenerate

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[W-1];
    assign side_out  = side_reg[W-1];

endmodule

// ----- sv/sdm_wave.sv -----
module sdm_wave (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [sdm_pkg::SIZE_W-1:0]         tx,
    input  logic [sdm_pkg::SIZE_W-1:0]         ty,
    input  logic [sdm_pkg::SAMPLE_W-1:0]       re,
    input  logic [sdm_pkg::SAMPLE_W-1:0]       im,
    input  sdm_pkg::cfg_t                      cfg,
    output logic                               out_valid,
    input  logic                               out_ready,
    output sdm_pkg::wave_t                     wave
);

    logic                              k_valid_reg;
    logic                              q_valid_reg;
    logic                              adv_k;
    logic                              adv_q;
    logic [sdm_pkg::KMAG_W-1:0]        kx_reg;
    logic [sdm_pkg::KMAG_W-1:0]        ky_reg;
    logic                              kx_neg_reg;
    logic                              ky_neg_reg;
    logic [sdm_pkg::SAMPLE_W-1:0]      re_reg;
    logic [sdm_pkg::SAMPLE_W-1:0]      im_reg;
    sdm_pkg::wave_t                    wave_reg;

    logic                              nx_neg;
    logic                              ny_neg;
    logic [sdm_pkg::SIZE_W-1:0]        nx;
    logic [sdm_pkg::SIZE_W-1:0]        ny;
    logic [sdm_pkg::KMAG_W-1:0]        kx_next;
    logic [sdm_pkg::KMAG_W-1:0]        ky_next;
    logic [sdm_pkg::KSQ_W-1:0]         kx_low;
    logic [sdm_pkg::KSQ_W-1:0]         ky_low;
    sdm_pkg::wave_t                    wave_next;

    assign adv_q    = !q_valid_reg || out_ready;
    assign adv_k    = !k_valid_reg || adv_q;
    assign in_ready = adv_k;

    // Index distance from the centering shift gives the wavenumber.
    assign nx_neg  = tx < cfg.shift_x;
    assign ny_neg  = ty < cfg.shift_y;
    assign nx      = nx_neg ? (cfg.shift_x - tx) : (tx - cfg.shift_x);
    assign ny      = ny_neg ? (cfg.shift_y - ty) : (ty - cfg.shift_y);
    assign kx_next = nx * cfg.step_kx;
    assign ky_next = ny * cfg.step_ky;

    assign kx_low = kx_reg[sdm_pkg::KSQ_W-1:0];
    assign ky_low = ky_reg[sdm_pkg::KSQ_W-1:0];

    always_comb
    begin
        wave_next.kx_mag  = kx_reg;
        wave_next.kx_neg  = kx_neg_reg;
        wave_next.ky_mag  = ky_reg;
        wave_next.ky_neg  = ky_neg_reg;
        wave_next.sqx_big = |kx_reg[sdm_pkg::KMAG_W-1:sdm_pkg::KSQ_W];
        wave_next.sqy_big = |ky_reg[sdm_pkg::KMAG_W-1:sdm_pkg::KSQ_W];
        wave_next.sqx     = kx_low * kx_low;
        wave_next.sqy     = ky_low * ky_low;
        wave_next.re      = re_reg;
        wave_next.im      = im_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_k)
            begin
                k_valid_reg <= in_valid;
            end
            if (adv_q)
            begin
                q_valid_reg <= k_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_k)
        begin
            kx_reg     <= kx_next;
            ky_reg     <= ky_next;
            kx_neg_reg <= nx_neg;
            ky_neg_reg <= ny_neg;
            re_reg     <= re;
            im_reg     <= im;
        end
        if (adv_q)
        begin
            wave_reg <= wave_next;
        end
    end

    assign out_valid = q_valid_reg;
    assign wave      = wave_reg;

endmodule

// ----- sv/sdm_scale.sv -----
module sdm_scale (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  sdm_pkg::wave_t                      wave,
    input  logic [sdm_pkg::OP_W-1:0]            operation,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sdm_pkg::SAMPLE_W-1:0]        res0,
    output logic [sdm_pkg::SAMPLE_W-1:0]        res1,
    output logic                                sat
);

    localparam logic [sdm_pkg::FAC_W-1:0] FAC_CLAMP = sdm_pkg::FAC_W'(1) << sdm_pkg::CLAMP_EXP;
    localparam logic [sdm_pkg::P_W-1:0] LIMIT_POS =
        (sdm_pkg::P_W'(1) << (sdm_pkg::SAMPLE_W - 1)) - sdm_pkg::P_W'(1);
    localparam logic [sdm_pkg::P_W-1:0] LIMIT_NEG = sdm_pkg::P_W'(1) << (sdm_pkg::SAMPLE_W - 1);

    logic f_valid_reg;
    logic m_valid_reg;
    logic r_valid_reg;
    logic adv_f;
    logic adv_m;
    logic adv_r;

    logic [sdm_pkg::FAC_W-1:0]    fac_reg [2];
    logic [sdm_pkg::SAMPLE_W-1:0] smag_reg [2];
    logic                         xneg_reg [2];
    logic [sdm_pkg::SAMPLE_W-1:0] raw_reg [2];
    logic                         pass_reg;

    logic [sdm_pkg::PLO_W-1:0]    plo_reg [2];
    logic [sdm_pkg::PHI_W-1:0]    phi_reg [2];
    logic                         mneg_reg [2];
    logic [sdm_pkg::SAMPLE_W-1:0] mraw_reg [2];
    logic                         mpass_reg;

    logic [sdm_pkg::SAMPLE_W-1:0] res_reg [2];
    logic                         sat_reg;

    logic [sdm_pkg::FAC_W-1:0]    sqx_f;
    logic [sdm_pkg::FAC_W-1:0]    sqy_f;
    logic [sdm_pkg::FAC_W:0]      lap_sum;
    logic [sdm_pkg::FAC_W-1:0]    lap_f;
    logic [sdm_pkg::FAC_W-1:0]    fac_next [2];
    logic                         fneg_next [2];
    logic [sdm_pkg::SAMPLE_W-1:0] samp_next [2];
    logic                         pass_next;
    logic [sdm_pkg::SAMPLE_W-1:0] res_next [2];
    logic                         lane_sat [2];

    assign adv_r    = !r_valid_reg || out_ready;
    assign adv_m    = !m_valid_reg || adv_r;
    assign adv_f    = !f_valid_reg || adv_m;
    assign in_ready = adv_f;

    assign sqx_f   = wave.sqx_big ? FAC_CLAMP : sdm_pkg::FAC_W'(wave.sqx >> sdm_pkg::FRAC_W);
    assign sqy_f   = wave.sqy_big ? FAC_CLAMP : sdm_pkg::FAC_W'(wave.sqy >> sdm_pkg::FRAC_W);
    assign lap_sum = {1'b0, sqx_f} + {1'b0, sqy_f};
    assign lap_f   = (lap_sum > {1'b0, FAC_CLAMP}) ? FAC_CLAMP : lap_sum[sdm_pkg::FAC_W-1:0];

    // Lane 0 feeds the real result and lane 1 the imaginary one.
    always_comb
    begin
        fac_next[0]  = lap_f;
        fac_next[1]  = lap_f;
        fneg_next[0] = 1'b1;
        fneg_next[1] = 1'b1;
        samp_next[0] = wave.re;
        samp_next[1] = wave.im;
        pass_next    = 1'b0;
        case (operation)
            sdm_pkg::OP_LAPLACE:
            begin
                fac_next[0] = lap_f;
                fac_next[1] = lap_f;
            end
            sdm_pkg::OP_DDX:
            begin
                fac_next[0]  = sdm_pkg::FAC_W'(wave.kx_mag);
                fac_next[1]  = sdm_pkg::FAC_W'(wave.kx_mag);
                fneg_next[0] = !wave.kx_neg;
                fneg_next[1] = wave.kx_neg;
                samp_next[0] = wave.im;
                samp_next[1] = wave.re;
            end
            sdm_pkg::OP_DDY:
            begin
                fac_next[0]  = sdm_pkg::FAC_W'(wave.ky_mag);
                fac_next[1]  = sdm_pkg::FAC_W'(wave.ky_mag);
                fneg_next[0] = !wave.ky_neg;
                fneg_next[1] = wave.ky_neg;
                samp_next[0] = wave.im;
                samp_next[1] = wave.re;
            end
            sdm_pkg::OP_D2X:
            begin
                fac_next[0] = sqx_f;
                fac_next[1] = sqx_f;
            end
            sdm_pkg::OP_D2Y:
            begin
                fac_next[0] = sqy_f;
                fac_next[1] = sqy_f;
            end
            default:
            begin
                pass_next = 1'b1;
            end
        endcase
    end

    genvar l;
    generate
        for (l = 0; l < 2; l++)
        begin : g_lane
            logic                         sneg;
            logic [sdm_pkg::SAMPLE_W-1:0] smag_next;
            logic [sdm_pkg::PROD_W-1:0]   prod;
            logic [sdm_pkg::P_W-1:0]      p;
            logic                         neg;
            logic [sdm_pkg::P_W-1:0]      limit;
            logic [sdm_pkg::SAMPLE_W-1:0] pv;

            assign sneg      = samp_next[l][sdm_pkg::SAMPLE_W-1];
            assign smag_next = sneg ? (~samp_next[l] + 1'b1) : samp_next[l];

            assign prod  = {phi_reg[l], {sdm_pkg::FLO_W{1'b0}}}
                           + sdm_pkg::PROD_W'(plo_reg[l]);
            assign p     = prod[sdm_pkg::PROD_W-1:sdm_pkg::FRAC_W];
            assign neg   = mneg_reg[l] && (p != '0);
            assign limit = neg ? LIMIT_NEG : LIMIT_POS;
            assign lane_sat[l] = !mpass_reg && (p > limit);
            assign pv    = lane_sat[l] ? limit[sdm_pkg::SAMPLE_W-1:0]
                                       : p[sdm_pkg::SAMPLE_W-1:0];
            assign res_next[l] = mpass_reg ? mraw_reg[l] : (neg ? (~pv + 1'b1) : pv);

            always_ff @(posedge clk)
            begin
                if (adv_f)
                begin
                    fac_reg[l]  <= fac_next[l];
                    smag_reg[l] <= smag_next;
                    xneg_reg[l] <= fneg_next[l] ^ sneg;
                    raw_reg[l]  <= samp_next[l];
                end
                if (adv_m)
                begin
                    plo_reg[l]  <= fac_reg[l][sdm_pkg::FLO_W-1:0] * smag_reg[l];
                    phi_reg[l]  <= fac_reg[l][sdm_pkg::FAC_W-1:sdm_pkg::FLO_W] * smag_reg[l];
                    mneg_reg[l] <= xneg_reg[l];
                    mraw_reg[l] <= raw_reg[l];
                end
                if (adv_r)
                begin
                    res_reg[l] <= res_next[l];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_f)
            begin
                f_valid_reg <= in_valid;
            end
            if (adv_m)
            begin
                m_valid_reg <= f_valid_reg;
            end
            if (adv_r)
            begin
                r_valid_reg <= m_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_f)
        begin
            pass_reg <= pass_next;
        end
        if (adv_m)
        begin
            mpass_reg <= pass_reg;
        end
        if (adv_r)
        begin
            sat_reg <= lane_sat[0] || lane_sat[1];
        end
    end

    assign out_valid = r_valid_reg;
    assign res0      = res_reg[0];
    assign res1      = res_reg[1];
    assign sat       = sat_reg;

endmodule

// ----- sv/spectral_derivative_multiplier.sv -----
// Multiplies a stream of complex spectral samples by the selected derivative
// operator, one item per clock cycle at full rate while the output is not
// stalled. Items pass the input register and two bit-serial divider pipelines:
// 25 stages split the global index into row and column, and 26 more wrap
// both of them around the grid sizes, followed by two wavenumber stages and
// three multiply and saturate stages.
// Every stage stalls only when it holds an item that cannot move on, so bubbles
// are squeezed out and new items enter while a result waits at the output.
// Configuration is taken at any time on its own port and must only change
// while no item is in flight.
module spectral_derivative_multiplier (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sdm_pkg::CFG_ADDR_W-1:0]         cfg_index,
    input  logic [sdm_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [sdm_pkg::INDEX_W-1:0]            local_index,
    input  logic signed [sdm_pkg::SAMPLE_W-1:0]    sample_re,
    input  logic signed [sdm_pkg::SAMPLE_W-1:0]    sample_im,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [sdm_pkg::SAMPLE_W-1:0]    result_re,
    output logic signed [sdm_pkg::SAMPLE_W-1:0]    result_im,
    output logic                                   saturated
);

    localparam int SIDE_W = 2 * sdm_pkg::SAMPLE_W;

    logic [sdm_pkg::SIZE_W-1:0]  grid_x_reg;
    logic [sdm_pkg::SIZE_W-1:0]  grid_y_reg;
    logic [sdm_pkg::SIZE_W-1:0]  shift_x_reg;
    logic [sdm_pkg::SIZE_W-1:0]  shift_y_reg;
    logic [sdm_pkg::STEP_W-1:0]  step_kx_reg;
    logic [sdm_pkg::STEP_W-1:0]  step_ky_reg;
    logic [sdm_pkg::INDEX_W-1:0] slab_reg;
    logic [sdm_pkg::OP_W-1:0]    operation_reg;
    sdm_pkg::cfg_t               cfg;

    logic [sdm_pkg::SIZE_W-1:0]  gx_eff;
    logic [sdm_pkg::SIZE_W-1:0]  gy_eff;

    logic                          s0_valid_reg;
    logic [sdm_pkg::GLOBAL_W-1:0]  g_reg;
    logic [SIDE_W-1:0]             samp_reg;
    logic                          s0_adv;

    logic                          d1_in_ready;
    logic                          d1_valid;
    logic [sdm_pkg::GLOBAL_W-1:0]  d1_dividend [1];
    logic [sdm_pkg::SIZE_W-1:0]    d1_divisor [1];
    logic [sdm_pkg::GLOBAL_W-1:0]  d1_quot [1];
    logic [sdm_pkg::SIZE_W-1:0]    d1_rem [1];
    logic [SIDE_W-1:0]             d1_side;

    logic                          d2_in_ready;
    logic                          d2_valid;
    logic [sdm_pkg::WRAP_W-1:0]    d2_dividend [2];
    logic [sdm_pkg::SIZE_W-1:0]    d2_divisor [2];
    logic [sdm_pkg::SIZE_W-1:0]    d2_rem [2];
    logic [SIDE_W-1:0]             d2_side;

    logic                          w_in_ready;
    logic                          w_valid;
    sdm_pkg::wave_t                wave;
    logic                          sc_in_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_x_reg    <= sdm_pkg::SIZE_W'(256);
            grid_y_reg    <= sdm_pkg::SIZE_W'(256);
            shift_x_reg   <= sdm_pkg::SIZE_W'(128);
            shift_y_reg   <= sdm_pkg::SIZE_W'(128);
            step_kx_reg   <= sdm_pkg::STEP_W'(65536);
            step_ky_reg   <= sdm_pkg::STEP_W'(65536);
            slab_reg      <= '0;
            operation_reg <= sdm_pkg::OP_LAPLACE;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sdm_pkg::REG_GRID_X:    grid_x_reg    <= cfg_data[sdm_pkg::SIZE_W-1:0];
                sdm_pkg::REG_GRID_Y:    grid_y_reg    <= cfg_data[sdm_pkg::SIZE_W-1:0];
                sdm_pkg::REG_SHIFT_X:   shift_x_reg   <= cfg_data[sdm_pkg::SIZE_W-1:0];
                sdm_pkg::REG_SHIFT_Y:   shift_y_reg   <= cfg_data[sdm_pkg::SIZE_W-1:0];
                sdm_pkg::REG_STEP_KX:   step_kx_reg   <= cfg_data[sdm_pkg::STEP_W-1:0];
                sdm_pkg::REG_STEP_KY:   step_ky_reg   <= cfg_data[sdm_pkg::STEP_W-1:0];
                sdm_pkg::REG_SLAB:      slab_reg      <= cfg_data[sdm_pkg::INDEX_W-1:0];
                sdm_pkg::REG_OPERATION: operation_reg <= cfg_data[sdm_pkg::OP_W-1:0];
                default:                slab_reg      <= slab_reg;
            endcase
        end
    end

    // A size of zero acts as one, and sizes beyond the grid limit are held there.
    assign gx_eff = (grid_x_reg == '0) ? sdm_pkg::SIZE_W'(1) :
                    (grid_x_reg > sdm_pkg::SIZE_W'(sdm_pkg::GRID_MAX)) ?
                    sdm_pkg::SIZE_W'(sdm_pkg::GRID_MAX) : grid_x_reg;
    assign gy_eff = (grid_y_reg == '0) ? sdm_pkg::SIZE_W'(1) :
                    (grid_y_reg > sdm_pkg::SIZE_W'(sdm_pkg::GRID_MAX)) ?
                    sdm_pkg::SIZE_W'(sdm_pkg::GRID_MAX) : grid_y_reg;

    assign cfg.shift_x   = shift_x_reg;
    assign cfg.shift_y   = shift_y_reg;
    assign cfg.step_kx   = step_kx_reg;
    assign cfg.step_ky   = step_ky_reg;

    assign s0_adv   = !s0_valid_reg || d1_in_ready;
    assign in_ready = s0_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_adv)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_adv)
        begin
            g_reg    <= sdm_pkg::GLOBAL_W'(local_index) + sdm_pkg::GLOBAL_W'(slab_reg);
            samp_reg <= {sample_re, sample_im};
        end
    end

    assign d1_dividend[0] = g_reg;
    assign d1_divisor[0]  = gx_eff;

    sdm_div #(
        .W      (sdm_pkg::GLOBAL_W),
        .DW     (sdm_pkg::SIZE_W),
        .LANES  (1),
        .SIDE_W (SIDE_W)
    ) u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_valid_reg),
        .in_ready  (d1_in_ready),
        .dividend  (d1_dividend),
        .divisor   (d1_divisor),
        .side_in   (samp_reg),
        .out_valid (d1_valid),
        .out_ready (d2_in_ready),
        .quotient  (d1_quot),
        .remainder (d1_rem),
        .side_out  (d1_side)
    );

    // Lane 0 wraps the column around x, lane 1 the row around y.
    assign d2_dividend[0] = sdm_pkg::WRAP_W'(d1_rem[0]) + sdm_pkg::WRAP_W'(shift_x_reg);
    assign d2_dividend[1] = sdm_pkg::WRAP_W'(d1_quot[0]) + sdm_pkg::WRAP_W'(shift_y_reg);
    assign d2_divisor[0]  = gx_eff;
    assign d2_divisor[1]  = gy_eff;

    sdm_div #(
        .W      (sdm_pkg::WRAP_W),
        .DW     (sdm_pkg::SIZE_W),
        .LANES  (2),
        .SIDE_W (SIDE_W)
    ) u_wrap (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_valid),
        .in_ready  (d2_in_ready),
        .dividend  (d2_dividend),
        .divisor   (d2_divisor),
        .side_in   (d1_side),
        .out_valid (d2_valid),
        .out_ready (w_in_ready),
        .quotient  (),
        .remainder (d2_rem),
        .side_out  (d2_side)
    );

    sdm_wave u_wave (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d2_valid),
        .in_ready  (w_in_ready),
        .tx        (d2_rem[0]),
        .ty        (d2_rem[1]),
        .re        (d2_side[SIDE_W-1:sdm_pkg::SAMPLE_W]),
        .im        (d2_side[sdm_pkg::SAMPLE_W-1:0]),
        .cfg       (cfg),
        .out_valid (w_valid),
        .out_ready (sc_in_ready),
        .wave      (wave)
    );

    sdm_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (w_valid),
        .in_ready  (sc_in_ready),
        .wave      (wave),
        .operation (operation_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res0      (result_re),
        .res1      (result_im),
        .sat       (saturated)
    );

endmodule

// ----- sv/sdm_checker.sv -----
module sdm_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [sdm_pkg::SAMPLE_W-1:0]        result_re,
    input logic [sdm_pkg::SAMPLE_W-1:0]        result_im,
    input logic                                saturated
);

    localparam logic [sdm_pkg::SAMPLE_W-1:0] MAX_POS = {1'b0, {(sdm_pkg::SAMPLE_W-1){1'b1}}};
    localparam logic [sdm_pkg::SAMPLE_W-1:0] MAX_NEG = {1'b1, {(sdm_pkg::SAMPLE_W-1){1'b0}}};

    // A result held back by the consumer stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before it was taken");

    // A clipped result shows a full-scale value in at least one part.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            result_re == MAX_POS || result_re == MAX_NEG ||
            result_im == MAX_POS || result_im == MAX_NEG)
        else $error("saturation flagged without a clipped part");

    // The pipeline comes out of reset empty.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result offered right after reset");

    // A stalled result keeps its flag.
    a_sat_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(saturated))
        else $error("saturation flag changed while stalled");

endmodule

bind spectral_derivative_multiplier sdm_checker u_sdm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_re (result_re),
    .result_im (result_im),
    .saturated (saturated)
);
